### rtl/annexb_pkg.sv
// Shared types and constants of the Annex B NAL unit splitter.
package annexb_pkg;

  localparam int LengthBits = 24;
  localparam int UnitLenW   = 24;
  localparam int ByteW      = 8;
  localparam int TypeW      = 5;
  localparam int MaxResults = 4;
  localparam int ResIdxW    = $clog2(MaxResults);
  localparam int FifoDepth  = 2;

  localparam logic [TypeW-1:0] TypeIdr   = 5'd5;
  localparam logic [TypeW-1:0] TypeSei   = 5'd6;
  localparam logic [TypeW-1:0] TypeSps   = 5'd7;
  localparam logic [TypeW-1:0] TypePps   = 5'd8;
  localparam logic [ByteW-1:0] StartLast = 8'h01;

  typedef enum logic [0:0] {
    CfgDropSei       = 1'b0,
    CfgDropParamSets = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0]    payload_byte;
    logic [TypeW-1:0]    unit_type;
    logic                first_of_unit;
    logic                last_of_unit;
    logic                key_frame;
    logic [UnitLenW-1:0] unit_length;
  } res_t;

  typedef struct packed {
    res_t [MaxResults-1:0] res;
    logic [ResIdxW-1:0]    last_idx;
  } bundle_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

### rtl/annexb_front.sv
// Front end: start code detection, unit classification and result bundling.
module annexb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  stream_byte_i,
  input  logic                        end_of_stream_i,
  input  logic                        cfg_we_i,
  input  annexb_pkg::cfg_idx_e        cfg_index_i,
  input  logic                        cfg_data_i,
  input  annexb_pkg::q_status_t       q_status_i,
  output logic                        push_o,
  output annexb_pkg::bundle_t         bundle_o
);
  import annexb_pkg::*;

  typedef struct packed {
    logic                  hv;
    logic [ByteW-1:0]      hb;
    logic                  hf;
    logic [TypeW-1:0]      ct;
    logic                  sup;
    logic [LengthBits-1:0] bc;
  } hold_t;

  localparam logic [LengthBits-1:0] CountMax = '1;

  hold_t                 hold_q, hold_d;
  logic                  iv_q, iv_d;
  logic [1:0]            zr_q, zr_d;
  logic                  drop_sei_q, drop_ps_q;
  logic [2:0]            n;
  logic [2:0]            n_m1;
  res_t [MaxResults-1:0] r;

  function automatic res_t emit_res(hold_t h, logic last);
    res_t                           o;
    logic [LengthBits+UnitLenW-1:0] ext;
    ext             = {{UnitLenW{1'b0}}, h.bc};
    o.payload_byte  = h.hb;
    o.unit_type     = h.ct;
    o.first_of_unit = h.hf;
    o.last_of_unit  = last;
    o.key_frame     = (h.ct == TypeIdr);
    o.unit_length   = ext[UnitLenW-1:0];
    return o;
  endfunction

  function automatic hold_t release_byte(hold_t h, logic [ByteW-1:0] x, logic ds, logic dp);
    hold_t o;
    logic  first;
    o     = h;
    first = (h.bc == '0);
    if (first) begin
      o.ct  = x[TypeW-1:0];
      o.sup = ((o.ct == TypeSei) && ds) || (((o.ct == TypeSps) || (o.ct == TypePps)) && dp);
    end
    o.hb = x;
    o.hf = first;
    o.hv = 1'b1;
    if (h.bc != CountMax) begin
      o.bc = h.bc + {{(LengthBits-1){1'b0}}, 1'b1};
    end
    return o;
  endfunction

  always_comb begin
    hold_d = hold_q;
    zr_d   = zr_q;
    iv_d   = iv_q;
    n      = '0;
    r      = '0;
    if (stream_byte_i == '0) begin
      if (zr_d != 2'd2) zr_d = zr_d + 2'd1;
    end else if ((stream_byte_i == StartLast) && (zr_d == 2'd2)) begin
      if (hold_d.hv && !hold_d.sup) begin
        r[n[ResIdxW-1:0]] = emit_res(hold_d, 1'b1);
        n = n + 3'd1;
      end
      hold_d.hv = 1'b0;
      hold_d.hf = 1'b0;
      hold_d.bc = '0;
      zr_d      = 2'd0;
      iv_d      = 1'b1;
    end else begin
      if (iv_d) begin
        if (zr_d != 2'd0) begin
          if (hold_d.hv && !hold_d.sup) begin
            r[n[ResIdxW-1:0]] = emit_res(hold_d, 1'b0);
            n = n + 3'd1;
          end
          hold_d = release_byte(hold_d, '0, drop_sei_q, drop_ps_q);
        end
        if (zr_d == 2'd2) begin
          if (hold_d.hv && !hold_d.sup) begin
            r[n[ResIdxW-1:0]] = emit_res(hold_d, 1'b0);
            n = n + 3'd1;
          end
          hold_d = release_byte(hold_d, '0, drop_sei_q, drop_ps_q);
        end
        if (hold_d.hv && !hold_d.sup) begin
          r[n[ResIdxW-1:0]] = emit_res(hold_d, 1'b0);
          n = n + 3'd1;
        end
        hold_d = release_byte(hold_d, stream_byte_i, drop_sei_q, drop_ps_q);
      end
      zr_d = 2'd0;
    end
    if (end_of_stream_i) begin
      if (hold_d.hv && !hold_d.sup) begin
        r[n[ResIdxW-1:0]] = emit_res(hold_d, 1'b1);
        n = n + 3'd1;
      end
      hold_d.hv = 1'b0;
      hold_d.hf = 1'b0;
      hold_d.bc = '0;
      zr_d      = 2'd0;
      iv_d      = 1'b0;
    end
  end

  assign n_m1              = n - 3'd1;
  assign in_ready_o        = !q_status_i.full;
  assign push_o            = in_valid_i && in_ready_o && (n != 3'd0);
  assign bundle_o.res      = r;
  assign bundle_o.last_idx = n_m1[ResIdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      zr_q   <= '0;
      iv_q   <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      hold_q <= hold_d;
      zr_q   <= zr_d;
      iv_q   <= iv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_sei_q <= 1'b1;
      drop_ps_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDropSei:       drop_sei_q <= cfg_data_i;
        CfgDropParamSets: drop_ps_q  <= cfg_data_i;
        default:          drop_sei_q <= drop_sei_q;
      endcase
    end
  end

endmodule

### rtl/annexb_bundle_fifo.sv
// Short queue of result bundles between front end and output serializer.
module annexb_bundle_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  annexb_pkg::bundle_t   bundle_i,
  input  logic                  pop_i,
  output annexb_pkg::bundle_t   head_o,
  output annexb_pkg::q_status_t status_o
);
  import annexb_pkg::*;

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(FifoDepth);

  bundle_t         mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d  = (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + PtrW'(1);
      cnt_d = cnt_d + CntW'(1);
    end
    if (pop_i) begin
      rd_d  = (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + PtrW'(1);
      cnt_d = cnt_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

  assign head_o         = mem_q[rd_q];
  assign status_o.valid = (cnt_q != '0);
  assign status_o.full  = (cnt_q == DepthC);

endmodule

### rtl/annexb_back.sv
// Back end: serializes each bundle into output items, one per cycle while out_ready_i is high.
module annexb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  annexb_pkg::bundle_t   head_i,
  input  annexb_pkg::q_status_t status_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output annexb_pkg::res_t      res_o
);
  import annexb_pkg::*;

  logic [ResIdxW-1:0] idx_q, idx_d;
  logic               fire;

  assign out_valid_o = status_i.valid;
  assign res_o       = head_i.res[idx_q];
  assign fire        = out_valid_o && out_ready_i;
  assign pop_o       = fire && (idx_q == head_i.last_idx);

  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (fire) begin
      idx_d = idx_q + ResIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

### rtl/annexb_nal_unit_splitter_unit.sv
// Top level of the Annex B NAL unit splitter.
// Accepts one stream byte per cycle and hands out NAL unit payload bytes with
// type, first/last marks, key-frame flag and running length. A byte normally
// yields at most one item and then the block sustains one byte per cycle while
// the output accepts items. A byte that ends a run of pending zeros, or that
// ends the stream, can yield up to four items; the output serializer drains
// them one per cycle while out_ready_i is high, and input stalls only once the
// two-entry bundle queue between front end and serializer is full. Items are
// registered in that queue and are output once their bundle reaches its head.
module annexb_nal_unit_splitter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  payload_byte_o,
  output logic [4:0]  unit_type_o,
  output logic        first_of_unit_o,
  output logic        last_of_unit_o,
  output logic        key_frame_o,
  output logic [23:0] unit_length_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i
);
  import annexb_pkg::*;

  logic      push;
  logic      pop;
  bundle_t   bundle;
  bundle_t   head;
  q_status_t status;
  res_t      res;

  annexb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .stream_byte_i   (stream_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i      (cfg_data_i),
    .q_status_i      (status),
    .push_o          (push),
    .bundle_o        (bundle)
  );

  annexb_bundle_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  annexb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign payload_byte_o  = res.payload_byte;
  assign unit_type_o     = res.unit_type;
  assign first_of_unit_o = res.first_of_unit;
  assign last_of_unit_o  = res.last_of_unit;
  assign key_frame_o     = res.key_frame;
  assign unit_length_o   = res.unit_length;

endmodule
